[hw/rtl/tle_pkg.sv]
`timescale 1ns / 1ps
package tle_pkg;

  localparam int LINE_BYTES = 32;
  localparam int LEN_W      = $clog2(LINE_BYTES);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_WILL  = 8'hFB;
  localparam logic [7:0] CH_IAC   = 8'hFF;

  // What an accepted byte asks of the sequencer
  typedef enum logic [1:0] {
    K_NONE,
    K_CR,
    K_BS,
    K_PRINT
  } kind_t;

  // Which byte goes into the output register
  typedef enum logic [2:0] {
    E_CR,
    E_LF,
    E_GT,
    E_SP,
    E_BS,
    E_ECHO,
    E_CMD
  } emit_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR_CR,
    S_CR_LF,
    S_RD,
    S_CMD,
    S_PR_GT,
    S_PR_SP,
    S_BS1,
    S_BS_SP,
    S_BS2,
    S_ECHO
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    logic      rd_issue;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
    logic  line_empty;
    logic  cmd_final;
  } dp_status_t;

endpackage

[hw/rtl/tle_ctrl.sv]
`timescale 1ns / 1ps
module tle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tle_pkg::dp_status_t status,
  output tle_pkg::ctrl_cmd_t  cmd
);
  import tle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (status.kind)
            K_CR:    state_nxt = S_CR_CR;
            K_BS:    state_nxt = S_BS1;
            K_PRINT: state_nxt = S_ECHO;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CR_CR: if (status.out_free) state_nxt = S_CR_LF;
      S_CR_LF: begin
        if (status.out_free) state_nxt = status.line_empty ? S_PR_GT : S_RD;
      end
      S_RD:    state_nxt = S_CMD;
      S_CMD: begin
        if (status.out_free) state_nxt = status.cmd_final ? S_PR_GT : S_RD;
      end
      S_PR_GT: if (status.out_free) state_nxt = S_PR_SP;
      S_PR_SP: if (status.out_free) state_nxt = S_IDLE;
      S_BS1:   if (status.out_free) state_nxt = S_BS_SP;
      S_BS_SP: if (status.out_free) state_nxt = S_BS2;
      S_BS2:   if (status.out_free) state_nxt = S_IDLE;
      S_ECHO:  if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_sel  = E_CR;
    cmd.emit_last = 1'b0;
    cmd.rd_issue  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_CR_CR: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = E_CR;
      end
      S_CR_LF: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = E_LF;
      end
      S_RD: cmd.rd_issue = 1'b1;
      S_CMD: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = E_CMD;
      end
      S_PR_GT: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = E_GT;
      end
      S_PR_SP: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = E_SP;
        cmd.emit_last = 1'b1;
      end
      S_BS1: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = E_BS;
      end
      S_BS_SP: begin
        cmd.emit     = status.out_free;
        cmd.emit_sel = E_SP;
      end
      S_BS2: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = E_BS;
        cmd.emit_last = 1'b1;
      end
      S_ECHO: begin
        cmd.emit      = status.out_free;
        cmd.emit_sel  = E_ECHO;
        cmd.emit_last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/tle_datapath.sv]
`timescale 1ns / 1ps
module tle_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          rx_byte,
  input  tle_pkg::ctrl_cmd_t  cmd,
  output tle_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_to_command,
  output logic                out_line_end,
  output logic                out_last
);
  import tle_pkg::*;

  logic             iac_r,  iac_nxt;
  logic             skip_r, skip_nxt;
  logic [LEN_W-1:0] len_r,  len_nxt;
  logic [LEN_W-1:0] idx_r,  idx_nxt;
  logic [7:0]       byte_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       line_mem [LINE_BYTES];

  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r;
  logic             ocmd_r;
  logic             oend_r;
  logic             olast_r;

  logic             cmd_final;
  logic [7:0]       emit_byte;
  kind_t            kind;

  assign cmd_final = ({1'b0, idx_r} + (LEN_W+1)'(1)) == {1'b0, len_r};

  always_comb begin
    kind = K_NONE;
    if (skip_r || iac_r || rx_byte == CH_IAC || rx_byte == CH_LF) begin
      kind = K_NONE;
    end else if (rx_byte == CH_CR) begin
      kind = K_CR;
    end else if (rx_byte == CH_DEL || rx_byte == CH_BS) begin
      kind = (len_r != '0) ? K_BS : K_NONE;
    end else if (rx_byte < CH_SPACE) begin
      kind = K_NONE;
    end else if ({1'b0, len_r} < (LEN_W+1)'(LINE_BYTES - 1)) begin
      kind = K_PRINT;
    end
  end

  assign status.kind       = kind;
  assign status.out_free   = !ovalid_r || out_ready;
  assign status.line_empty = (len_r == '0);
  assign status.cmd_final  = cmd_final;

  // Telnet command tracking and line length
  always_comb begin
    iac_nxt  = iac_r;
    skip_nxt = skip_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    if (cmd.accept) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (iac_r) begin
        iac_nxt  = 1'b0;
        skip_nxt = (rx_byte >= CH_WILL);
      end else if (rx_byte == CH_IAC) begin
        iac_nxt = 1'b1;
      end
      if (kind == K_PRINT) len_nxt = len_r + LEN_W'(1);
      if (kind == K_BS)    len_nxt = len_r - LEN_W'(1);
    end
    if (cmd.emit && cmd.emit_sel == E_CMD) begin
      if (cmd_final) begin
        idx_nxt = '0;
        len_nxt = '0;
      end else begin
        idx_nxt = idx_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iac_r  <= 1'b0;
      skip_r <= 1'b0;
      len_r  <= '0;
      idx_r  <= '0;
    end else begin
      iac_r  <= iac_nxt;
      skip_r <= skip_nxt;
      len_r  <= len_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) byte_r <= rx_byte;
    if (cmd.accept && kind == K_PRINT) line_mem[len_r] <= rx_byte;
    if (cmd.rd_issue) rd_data_r <= line_mem[idx_r];
  end

  always_comb begin
    case (cmd.emit_sel)
      E_CR:    emit_byte = CH_CR;
      E_LF:    emit_byte = CH_LF;
      E_GT:    emit_byte = CH_GT;
      E_SP:    emit_byte = CH_SPACE;
      E_BS:    emit_byte = CH_BS;
      E_ECHO:  emit_byte = byte_r;
      E_CMD:   emit_byte = rd_data_r;
      default: emit_byte = CH_SPACE;
    endcase
  end

  // Output register: drop on transaction, reload on emit
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_ready) ovalid_nxt = 1'b0;
    if (cmd.emit)  ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      obyte_r <= emit_byte;
      ocmd_r  <= (cmd.emit_sel == E_CMD);
      oend_r  <= (cmd.emit_sel == E_CMD) && cmd_final;
      olast_r <= cmd.emit_last;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_byte       = obyte_r;
  assign out_to_command = ocmd_r;
  assign out_line_end   = oend_r;
  assign out_last       = olast_r;

endmodule

[hw/rtl/telnet_line_editor.sv]
`timescale 1ns / 1ps
// Telnet line editor: strips IAC sequences from received bytes, echoes the
// edited line back to the client and, on CR, hands the stored line to the
// command side (tuser[0] set, tuser[1] on its final character) followed by
// the prompt. tlast marks the final result of each input byte. One byte is
// taken at a time: the next is accepted only after every result of the last
// has been loaded into the output register. On CR each stored character is
// read from the line memory and then loaded into the output register; a
// stalled output holds the sequence.
module telnet_line_editor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] to_command, [1] line_end
  output logic       out_tlast
);
  import tle_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tle_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_tdata),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_to_command (out_tuser[0]),
    .out_line_end   (out_tuser[1]),
    .out_last       (out_tlast)
  );

endmodule

[verif/telnet_line_editor_checker.sv]
`timescale 1ns / 1ps
module telnet_line_editor_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic [1:0] out_tuser,  // [0] to_command, [1] line_end
  input  logic       out_tlast,
  output int         mismatches,
  output int         pending,
  output int         results_seen,
  output int         lines_seen
);
  import tle_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       to_cmd;
    logic       line_end;
    logic       fin;
  } tx_item_t;

  tx_item_t   tx_q [$];

  // Shadow of the editor state
  logic       iac_seen;
  logic       skip_opt;
  int         line_len;
  logic [7:0] line_mem [LINE_BYTES];

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  function automatic void push_tx(input logic [7:0] ch, input logic to_cmd,
                                  input logic line_end);
    tx_item_t item;
    item.ch       = ch;
    item.to_cmd   = to_cmd;
    item.line_end = line_end;
    item.fin      = 1'b0;
    tx_q.push_back(item);
  endfunction

  // Work out every result one received byte causes and queue them in order.
  function automatic void edit_byte(input logic [7:0] b);
    int       first;
    tx_item_t tail;
    first = tx_q.size();
    if (skip_opt) begin
      skip_opt = 1'b0;
    end else if (iac_seen) begin
      iac_seen = 1'b0;
      if (b >= CH_WILL) skip_opt = 1'b1;
    end else if (b == CH_IAC) begin
      iac_seen = 1'b1;
    end else if (b == CH_CR) begin
      push_tx(CH_CR, 1'b0, 1'b0);
      push_tx(CH_LF, 1'b0, 1'b0);
      for (int i = 0; i < line_len; i++) begin
        push_tx(line_mem[i], 1'b1, i == line_len - 1);
      end
      line_len = 0;
      push_tx(CH_GT, 1'b0, 1'b0);
      push_tx(CH_SPACE, 1'b0, 1'b0);
    end else if (b == CH_BS || b == CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        push_tx(CH_BS, 1'b0, 1'b0);
        push_tx(CH_SPACE, 1'b0, 1'b0);
        push_tx(CH_BS, 1'b0, 1'b0);
      end
    end else if (b >= CH_SPACE && line_len < LINE_BYTES - 1) begin
      // LF and other control bytes fall through; a full line drops the byte
      line_mem[line_len] = b;
      line_len++;
      push_tx(b, 1'b0, 1'b0);
    end
    if (tx_q.size() > first) begin
      tail = tx_q.pop_back();
      tail.fin = 1'b1;
      tx_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    tx_item_t want;
    if (!rst_n) begin
      iac_seen = 1'b0;
      skip_opt = 1'b0;
      line_len = 0;
      tx_q.delete();
    end else begin
      if (in_tvalid && in_tready) edit_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (tx_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %02h tuser %b tlast %b",
                                  out_tdata, out_tuser, out_tlast));
        end else begin
          want = tx_q.pop_front();
          if (out_tdata !== want.ch)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_tdata, want.ch));
          if (out_tuser[0] !== want.to_cmd)
            flag_mismatch($sformatf("to_command %b, want %b", out_tuser[0], want.to_cmd));
          if (out_tuser[1] !== want.line_end)
            flag_mismatch($sformatf("line_end %b, want %b", out_tuser[1], want.line_end));
          if (out_tlast !== want.fin)
            flag_mismatch($sformatf("last %b, want %b", out_tlast, want.fin));
        end
        if (out_tuser[1] === 1'b1) lines_seen++;
        results_seen++;
      end
    end
    pending = tx_q.size();
  end

endmodule

[verif/tb_telnet_line_editor.sv]
`timescale 1ns / 1ps
module tb_telnet_line_editor;
  import tle_pkg::*;

  localparam int          RANDOM_BYTES = 105;
  localparam int          WATCHDOG     = 2000;
  localparam int          SETTLE       = 100;
  localparam logic [7:0]  CMD_DONT     = 8'hFE;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  int   mismatches;
  int   pending;
  int   results_seen;
  int   lines_seen;
  int   bytes_sent = 0;
  int   quiet      = 0;
  int   hold_left  = 0;
  int   run_left   = 0;
  logic idle_en    = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  telnet_line_editor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  telnet_line_editor_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .lines_seen   (lines_seen)
  );

  // Receiver: random stall bursts mixed with stretches of steady ready
  always @(negedge clk) begin
    if (!rst_n || !idle_en) begin
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (run_left > 0) begin
      out_tready <= 1'b1;
      run_left   <= run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
      run_left   <= $urandom_range(0, 20);
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG, pending);
        $display("** telnet_line_editor: FAILED **");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Hold off the sender until every queued result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] any_printable();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(8'h80, 8'hFE));
    else c = 8'($urandom_range(8'h20, 8'h7E));
    return c;
  endfunction

  task automatic send_iac();
    logic [7:0] op;
    if ($urandom_range(0, 1) == 0) op = 8'($urandom_range(8'hF0, 8'hFF));
    else op = 8'($urandom_range(0, 255));
    send_byte(CH_IAC);
    send_byte(op);
    if (op >= CH_WILL) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] opening [$];
    int         directed;
    int         pick;
    int         n;
    bit         long_done;
    bit         mid_drained;

    opening = '{CH_CR, CH_BS, CH_DEL, 8'h00, CH_LF, 8'h1F,
                CH_SPACE, 8'h7E, 8'h80, 8'hFE, CH_BS, CH_DEL,
                CH_IAC, CH_WILL, 8'h03, CH_IAC, CH_IAC, CH_IAC, CH_CR,
                8'h41, CH_IAC, CMD_DONT, CH_IAC, CH_CR};
    long_done   = 1'b0;
    mid_drained = 1'b0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening[i]) send_byte(opening[i]);
    directed = bytes_sent;
    drain();

    while (bytes_sent < directed + RANDOM_BYTES) begin
      if (bytes_sent > directed + RANDOM_BYTES - 30) idle_en <= 1'b0;
      if (!mid_drained && bytes_sent >= directed + RANDOM_BYTES / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      pick = long_done ? $urandom_range(0, 11) : 11;
      case (pick)
        0, 1, 2, 3, 4, 5: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0:       send_byte(CH_BS);
              1:       send_byte(CH_DEL);
              2:       send_iac();
              default: send_byte(any_printable());
            endcase
          end
          send_byte(CH_CR);
          if ($urandom_range(0, 1) == 0) send_byte(CH_LF);
        end
        6, 7: send_iac();
        8, 9: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        10: begin
          send_byte(8'($urandom_range(0, 8'h1F)));
          send_byte(($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL);
        end
        default: begin
          // fill the line, possibly past capacity so the tail is dropped, then hand it over
          repeat ($urandom_range(LINE_BYTES - 3, LINE_BYTES + 4))
            send_byte(any_printable());
          send_byte(CH_CR);
          long_done = 1'b1;
        end
      endcase
    end

    drain();
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d received bytes (%0d directed), IAC options, edits, overruns",
             bytes_sent, directed);
    $display("checked %0d results, %0d command lines handed over",
             results_seen, lines_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("** telnet_line_editor: PASSED **");
    end else begin
      $display("** telnet_line_editor: FAILED **");
    end
    $finish;
  end

endmodule
